// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 32;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
  localparam int KIND_BITS     = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the store and load the result register
  } spq_cmd_t;

endpackage

// ===== hdl/spq_datapath.sv =====
module spq_datapath
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  spq_cmd_t                 cmd,
  input  logic [KIND_BITS-1:0]     in_kind,
  input  logic [PRIORITY_BITS-1:0] in_priority,
  input  logic [PAYLOAD_BITS-1:0]  in_payload,
  output logic                     accepted,
  output logic                     is_empty,
  output logic [COUNT_BITS-1:0]    entry_count,
  output logic [PRIORITY_BITS-1:0] head_priority,
  output logic [PAYLOAD_BITS-1:0]  head_payload
);

  logic [KIND_BITS-1:0]     kind;
  logic [PRIORITY_BITS-1:0] new_priority;
  logic [PAYLOAD_BITS-1:0]  new_payload;

  // sorted store, slot 0 is the head
  logic [PRIORITY_BITS-1:0] slot_priority [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  slot_payload  [CAPACITY];
  logic [COUNT_BITS-1:0]    occupancy;

  logic [PRIORITY_BITS-1:0] slot_priority_next [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  slot_payload_next  [CAPACITY];
  logic [COUNT_BITS-1:0]    occupancy_next;
  logic                     ok;
  logic [CAPACITY-1:0]      stays;
  logic                     full;

  always_comb begin
    // stays[i]: slot i is valid and not below the new entry; a prefix of ones
    for (int i = 0; i < CAPACITY; i++) begin
      stays[i] = (COUNT_BITS'(i) < occupancy) && (slot_priority[i] >= new_priority);
    end
    full = (occupancy == COUNT_BITS'(CAPACITY));

    slot_priority_next = slot_priority;
    slot_payload_next  = slot_payload;
    occupancy_next     = occupancy;
    ok                 = 1'b0;

    case (kind)
      KIND_PUSH: begin
        if (!full) begin
          ok = 1'b1;
          occupancy_next = occupancy + 1'b1;
          if (!stays[0]) begin
            slot_priority_next[0] = new_priority;
            slot_payload_next[0]  = new_payload;
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (!stays[i]) begin
              if (stays[i-1]) begin
                slot_priority_next[i] = new_priority;
                slot_payload_next[i]  = new_payload;
              end else begin
                slot_priority_next[i] = slot_priority[i-1];
                slot_payload_next[i]  = slot_payload[i-1];
              end
            end
          end
        end
      end
      KIND_POP: begin
        if (occupancy != '0) begin
          ok = 1'b1;
          occupancy_next = occupancy - 1'b1;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            slot_priority_next[i] = slot_priority[i+1];
            slot_payload_next[i]  = slot_payload[i+1];
          end
        end
      end
      KIND_CLEAR: begin
        ok = 1'b1;
        occupancy_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind         <= in_kind;
      new_priority <= in_priority;
      new_payload  <= in_payload;
    end
    if (cmd.exec) begin
      slot_priority <= slot_priority_next;
      slot_payload  <= slot_payload_next;
      accepted      <= ok;
      is_empty      <= (occupancy_next == '0);
      entry_count   <= occupancy_next;
      head_priority <= (occupancy_next != '0) ? slot_priority_next[0] : '0;
      head_payload  <= (occupancy_next != '0) ? slot_payload_next[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.exec) begin
      occupancy <= occupancy_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= COUNT_BITS'(CAPACITY))
    else $error("occupancy above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && kind == KIND_CLEAR) |=> (occupancy == '0))
    else $error("clear left entries behind");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (occupancy > COUNT_BITS'(1)) |-> (slot_priority[0] >= slot_priority[1]))
    else $error("head slots out of order");

endmodule

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output spq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);
  assign cmd.load = s_tvalid && s_tready;
  // result register must be free or draining this cycle
  assign cmd.exec = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.exec) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC && !s_tready))
    else $error("input taken while a transaction is in flight");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("executed transaction produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.exec)
    else $error("waiting result overwritten");

endmodule

// ===== hdl/stable_priority_queue_core.sv =====
// Stable priority queue: up to CAPACITY entries of (priority, payload) held
// in descending priority order; equal priorities leave in arrival order.
// Slave channel: one transaction per operation. s_tuser holds the kind
// (push, pop head, clear), s_tdata the priority and payload of a push.
// Master channel: one result per operation with accepted flag, empty flag,
// entry count and the head entry after the operation (zero when empty).
// A push to a full queue or a pop of an empty one returns accepted = 0 and
// leaves the queue untouched, as does the unused kind code.
// Each input waits in the load registers until it is executed and its
// result registered; no new operation is taken before then. Input capture
// and the parallel shift of the slot registers alternate under the controller.
// If the receiver stalls, the result waits in the output register; one
// further input is taken and held until that register frees.
// Reset empties the queue at once and drops any pending result.
module stable_priority_queue_core
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] entry_priority, [39:8] entry_payload
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [0] accepted, [1] is_empty, [6:2] entry_count,
                                 // [14:7] head_priority, [46:15] head_payload, [47] zero
);

  spq_cmd_t                 cmd;
  logic                     accepted;
  logic                     is_empty;
  logic [COUNT_BITS-1:0]    entry_count;
  logic [PRIORITY_BITS-1:0] head_priority;
  logic [PAYLOAD_BITS-1:0]  head_payload;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  spq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_kind       (s_tuser),
    .in_priority   (s_tdata[7:0]),
    .in_payload    (s_tdata[39:8]),
    .accepted      (accepted),
    .is_empty      (is_empty),
    .entry_count   (entry_count),
    .head_priority (head_priority),
    .head_payload  (head_payload)
  );

  assign m_tdata = {1'b0, head_payload, head_priority, entry_count, is_empty, accepted};

endmodule

// ===== tb/sv/stable_priority_queue_core_tb.sv =====
module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction
  localparam int LATENCY_PAD = 8;

  typedef struct {
    logic                     accepted;
    logic                     is_empty;
    logic [COUNT_BITS-1:0]    entry_count;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [PAYLOAD_BITS-1:0]  head_payload;
  } queue_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] entry_priority, [39:8] entry_payload
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [0] accepted, [1] is_empty, [6:2] entry_count,
                               // [14:7] head_priority, [46:15] head_payload

  // shadow of the sorted store
  logic [PRIORITY_BITS-1:0] shadow_prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  shadow_payload [CAPACITY];
  int                       shadow_count = 0;

  queue_result_t expected_results[$];
  int fault_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  stable_priority_queue_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void predict_queue_op(input logic [KIND_BITS-1:0] kind,
                                           input logic [PRIORITY_BITS-1:0] prio,
                                           input logic [PAYLOAD_BITS-1:0] payload);
    queue_result_t r;
    int pos;
    r.accepted = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (shadow_count < CAPACITY) begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i]    = shadow_prio[i-1];
            shadow_payload[i] = shadow_payload[i-1];
          end
          shadow_prio[pos]    = prio;
          shadow_payload[pos] = payload;
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_POP: begin
        if (shadow_count > 0) begin
          for (int i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1]    = shadow_prio[i];
            shadow_payload[i-1] = shadow_payload[i];
          end
          shadow_count--;
          r.accepted = 1'b1;
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.is_empty      = (shadow_count == 0);
    r.entry_count   = COUNT_BITS'(shadow_count);
    r.head_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
    r.head_payload  = (shadow_count > 0) ? shadow_payload[0] : '0;
    expected_results.push_back(r);
  endfunction

  function automatic void check_result(input logic [47:0] word);
    queue_result_t got;
    queue_result_t want;
    got.accepted      = word[0];
    got.is_empty      = word[1];
    got.entry_count   = word[6:2];
    got.head_priority = word[14:7];
    got.head_payload  = word[46:15];
    if (expected_results.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected result: acc=%0d empty=%0d cnt=%0d prio=%0d payload=%h",
                 got.accepted, got.is_empty, got.entry_count, got.head_priority,
                 got.head_payload);
      return;
    end
    want = expected_results.pop_front();
    if (got.accepted !== want.accepted || got.is_empty !== want.is_empty ||
        got.entry_count !== want.entry_count || got.head_priority !== want.head_priority ||
        got.head_payload !== want.head_payload) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch: exp acc=%0d empty=%0d cnt=%0d prio=%0d payload=%h | got acc=%0d empty=%0d cnt=%0d prio=%0d payload=%h",
                 want.accepted, want.is_empty, want.entry_count, want.head_priority,
                 want.head_payload, got.accepted, got.is_empty, got.entry_count,
                 got.head_priority, got.head_payload);
    end
  endfunction

  // result side: check, then decide readiness for the next edge
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1)
      check_result(m_tdata);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_op(input logic [KIND_BITS-1:0] kind,
                         input logic [PRIORITY_BITS-1:0] prio,
                         input logic [PAYLOAD_BITS-1:0] payload);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {payload, prio};
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_queue_op(kind, prio, payload);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_op(KIND_POP, 8'd0, 32'd0);                 // pop of empty queue
    send_op(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);     // ignored kind when empty
    send_op(KIND_PUSH, 8'hFF, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 8'h00, 32'h0000_0000);
    send_op(KIND_PUSH, 8'd7, 32'h1111_1111);        // equal priorities keep order
    send_op(KIND_PUSH, 8'd7, 32'h2222_2222);
    send_op(KIND_PUSH, 8'd7, 32'h3333_3333);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_UNUSED, 8'd0, 32'd0);
    send_op(KIND_CLEAR, 8'd0, 32'd0);
    for (int i = 0; i < CAPACITY; i++)
      send_op(KIND_PUSH, PRIORITY_BITS'(i % 3), PAYLOAD_BITS'(32'hA000_0000 + i));
    send_op(KIND_PUSH, 8'hFF, 32'hDEAD_BEEF);       // refused: full
    send_op(KIND_CLEAR, 8'd0, 32'd0);
    wait_drained();
  endtask

  task automatic random_ops(input int n);
    logic [KIND_BITS-1:0]     kind;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
    int run_left;
    int push_pct;
    int r;
    run_left = 0;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      // pick fill-heavy or drain-heavy runs at random to reach full and empty often
      if (run_left == 0) begin
        push_pct = $urandom_range(1) ? 75 : 30;
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 2)
        kind = KIND_UNUSED;
      else if (r < 5)
        kind = KIND_CLEAR;
      else if ($urandom_range(99) < push_pct)
        kind = KIND_PUSH;
      else
        kind = KIND_POP;
      case ($urandom_range(3))
        0: prio = PRIORITY_BITS'($urandom_range(3));
        1: prio = $urandom_range(1) ? '1 : '0;
        default: prio = PRIORITY_BITS'($urandom_range(255));
      endcase
      case ($urandom_range(15))
        0: payload = '0;
        1: payload = '1;
        default: payload = $urandom;
      endcase
      send_op(kind, prio, payload);
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 250;  // sink holds off while items keep coming
    random_ops(40);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 65, 0, 37};
    stall_set = '{0, 0, 65, 37};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_set[ph];
      sink_stall_pct = stall_set[ph];
      random_ops(345);
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (fault_count == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/stable_priority_queue_core.sv
tb/sv/stable_priority_queue_core_tb.sv
